[sv/plc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// plc_pkg: shared types and constants of the positional list core
// Operation and status codes, cell control word, controller states.
// ============================================================================
package plc_pkg;

    localparam int ELEM_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 6;
    // cell index width; covers every capacity up to 64
    localparam int IDX_W     = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_READOUT   = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;   // insert or delete slot
        logic [IDX_W-1:0] wrap;  // last occupied slot during readout rotation
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

endpackage

[sv/plc_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// plc_in_if / plc_out_if: word channels of the positional list core
// Valid/ready handshake; a word moves when both are high at a clock edge.
// ============================================================================
interface plc_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [5:0]         position;
    logic signed [31:0] value;

    modport source (output valid, operation, position, value, input ready);
    modport sink   (input valid, operation, position, value, output ready);
endinterface

interface plc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               element_valid;
    logic [5:0]         count_after;
    logic               last;

    modport source (output valid, status, element, element_valid, count_after, last,
                     input ready);
    modport sink   (input valid, status, element, element_valid, count_after, last,
                     output ready);
endinterface

[sv/positional_list_insert_delete_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// positional_list_insert_delete_core: ordered list with positional edits
// Insert/delete at front, back or position, and full readout, on a row of
// shifting cells.
// ============================================================================
//
//  channel | dir | word contents                                   | words per op
//  --------+-----+-------------------------------------------------+--------------
//  i_in    | in  | operation, position, value                      | 1
//  o_out   | out | status, element, element_valid, count_after,    | 1, or count
//          |     | last                                            | on readout
//
// Steps: an insert or delete is accepted, then executed; the cells from the
// edited slot on shift in the execute step, and a back delete only lowers
// the count. A readout: the row rotates one slot per cycle while the output
// register is free, and the head cell feeds the output register.
// Reset: synchronous, active low; clears the count, the controller and the
// output valid. Cell contents are not reset.
// Stalls: a full output register holds the controller; a new word is taken
// while the previous result still waits downstream.
// ============================================================================
module positional_list_insert_delete_core #(
    parameter int CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    plc_in_if.sink        i_in,
    plc_out_if.source     o_out
);
    import plc_pkg::*;

    // count needs to hold CAPACITY itself
    localparam int CW   = $clog2(CAPACITY + 1);
    // common width for position/count compares
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // controller state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_rd, n_rd;

    // latched input word
    logic [OP_W-1:0]    r_op_raw, n_op_raw;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [ELEM_W-1:0]  r_val, n_val;

    // output register
    logic               r_out_v, n_out_v;
    t_status            r_out_status, n_out_status;
    logic [ELEM_W-1:0]  r_out_elem, n_out_elem;
    logic               r_out_ev, n_out_ev;
    logic [CW-1:0]      r_out_cnt, n_out_cnt;
    logic               r_out_last, n_out_last;

    t_cell_ctl          w_ctl;
    logic [ELEM_W-1:0]  w_data [CAPACITY];

    logic               w_full, w_empty, w_slot_free, w_accept;
    logic [CMPW-1:0]    w_pos_x, w_cnt_x;

    assign w_full      = (r_count == CAP_C);
    assign w_empty     = (r_count == '0);
    assign w_slot_free = !r_out_v || o_out.ready;
    assign w_pos_x     = CMPW'(r_pos);
    assign w_cnt_x     = CMPW'(r_count);
    assign w_accept    = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == S_IDLE);

    // ---------------------------------------------------------------- cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ELEM_W-1:0] w_left, w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            plc_cell #(
                .INDEX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_value (r_val),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_data[0]),
                .o_data  (w_data[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------ controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rd    <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd    <= n_rd;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_raw     <= n_op_raw;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_ev     <= n_out_ev;
        r_out_cnt    <= n_out_cnt;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd         = r_rd;
        n_op_raw     = r_op_raw;
        n_pos        = r_pos;
        n_val        = r_val;
        n_out_v      = r_out_v && !o_out.ready;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_ev     = r_out_ev;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;
        w_ctl.op     = CELL_HOLD;
        w_ctl.idx    = '0;
        w_ctl.wrap   = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op_raw = i_in.operation;
                    n_pos    = i_in.position;
                    n_val    = i_in.value;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                if (w_slot_free) begin
                    n_state      = S_IDLE;
                    n_out_v      = 1'b1;
                    n_out_status = ST_OK;
                    n_out_elem   = '0;
                    n_out_ev     = 1'b0;
                    n_out_last   = 1'b1;
                    case (r_op_raw)
                        OP_INS_FRONT: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_ctl.op = CELL_INS;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_INS_BACK: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_ctl.op  = CELL_INS;
                                w_ctl.idx = IDX_W'(r_count);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_INS_POS: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else if (w_pos_x == '0 || w_pos_x > w_cnt_x + 1'b1) begin
                                n_out_status = ST_BADPOS;
                            end else begin
                                w_ctl.op  = CELL_INS;
                                w_ctl.idx = IDX_W'(r_pos - 1'b1);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        OP_DEL_FRONT: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                w_ctl.op = CELL_DEL;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        OP_DEL_BACK: begin
                            // tail slot simply drops out of the count
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_DEL_POS: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                                n_out_status = ST_BADPOS;
                            end else begin
                                w_ctl.op  = CELL_DEL;
                                w_ctl.idx = IDX_W'(r_pos - 1'b1);
                                n_count   = r_count - 1'b1;
                            end
                        end
                        OP_READOUT: begin
                            // empty list: one word with no element
                            if (!w_empty) begin
                                n_out_v = r_out_v && !o_out.ready;
                                n_state = S_READ;
                                n_rd    = '0;
                            end
                        end
                        default: begin
                            n_out_status = ST_BADPOS;
                        end
                    endcase
                    n_out_cnt = n_count;
                end
            end

            S_READ: begin
                if (w_slot_free) begin
                    n_out_v      = 1'b1;
                    n_out_status = ST_OK;
                    n_out_elem   = w_data[0];
                    n_out_ev     = 1'b1;
                    n_out_cnt    = r_count;
                    n_out_last   = (r_rd == r_count - 1'b1);
                    w_ctl.op     = CELL_ROT;
                    w_ctl.wrap   = IDX_W'(r_count - 1'b1);
                    n_rd         = r_rd + 1'b1;
                    if (r_rd == r_count - 1'b1) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- output
    assign o_out.valid         = r_out_v;
    assign o_out.status        = r_out_status;
    assign o_out.element       = r_out_elem;
    assign o_out.element_valid = r_out_ev;
    assign o_out.count_after   = CNT_OUT_W'(r_out_cnt);
    assign o_out.last          = r_out_last;

endmodule

[sv/plc_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// plc_cell: one slot of the list
// Holds one element; takes from its left or right neighbor on shifts.
// ============================================================================
module plc_cell #(
    parameter int INDEX = 0
) (
    input  logic                        i_clk,
    input  plc_pkg::t_cell_ctl          i_ctl,
    input  logic [plc_pkg::ELEM_W-1:0]  i_value,
    input  logic [plc_pkg::ELEM_W-1:0]  i_left,
    input  logic [plc_pkg::ELEM_W-1:0]  i_right,
    input  logic [plc_pkg::ELEM_W-1:0]  i_head,
    output logic [plc_pkg::ELEM_W-1:0]  o_data
);
    import plc_pkg::*;

    localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

    logic [ELEM_W-1:0] r_data;
    logic [ELEM_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INS: begin
                if (ME > i_ctl.idx) begin
                    n_data = i_left;
                end else if (ME == i_ctl.idx) begin
                    n_data = i_value;
                end
            end
            CELL_DEL: begin
                if (ME >= i_ctl.idx) begin
                    n_data = i_right;
                end
            end
            CELL_ROT: begin
                // rotate the occupied slots toward the head, head wraps to the tail
                if (ME == i_ctl.wrap) begin
                    n_data = i_head;
                end else if (ME < i_ctl.wrap) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench of positional_list_insert_delete_core
// Drives list operations through the input channel and predicts every output
// word with a shadow copy of the list. The words are compared field by field
// in arrival order. Runs a directed opening, then random traffic under
// several idle/stall mixes and one long output hold-off.
// ============================================================================
module tb;
    import plc_pkg::*;

    localparam int CAPACITY = 32;
    localparam logic [OP_W-1:0] OP_RESERVED = 3'd7;   // unused code, rejected
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_status                   status;
        logic signed [ELEM_W-1:0]  element;
        logic                      element_valid;
        logic [CNT_OUT_W-1:0]      count_after;
        logic                      last;
    } t_list_word;

    // ------------------------------------------------------------------------
    // shadow list plus the queue of output words it predicts
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [ELEM_W-1:0] shadow_list [CAPACITY];
        int                       shadow_count;
        t_list_word               expected_words [$];
        int                       mismatches;

        function new();
            shadow_count = 0;
            mismatches   = 0;
        endfunction

        function int stored();
            return shadow_count;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push_word(t_status st, logic signed [ELEM_W-1:0] el,
                                logic ev, logic lst);
            t_list_word w;
            w.status        = st;
            w.element       = el;
            w.element_valid = ev;
            w.count_after   = shadow_count[CNT_OUT_W-1:0];
            w.last          = lst;
            expected_words.push_back(w);
        endfunction

        function void open_slot(int idx, logic signed [ELEM_W-1:0] val);
            for (int i = shadow_count; i > idx; i--)
                shadow_list[i] = shadow_list[i-1];
            shadow_list[idx] = val;
            shadow_count++;
        endfunction

        function void close_slot(int idx);
            for (int i = idx; i + 1 < shadow_count; i++)
                shadow_list[i] = shadow_list[i+1];
            shadow_count--;
        endfunction

        // accepted request: update the shadow list, queue the words it causes
        function void log_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                  logic signed [ELEM_W-1:0] val);
            t_status st;
            bit      full;
            bit      empty;
            int      p;
            st    = ST_OK;
            full  = shadow_count >= CAPACITY;
            empty = shadow_count == 0;
            p     = int'(pos);
            case (op)
                OP_INS_FRONT: begin
                    if (full) st = ST_FULL;
                    else open_slot(0, val);
                end
                OP_INS_BACK: begin
                    if (full) st = ST_FULL;
                    else open_slot(shadow_count, val);
                end
                OP_INS_POS: begin
                    if (full) st = ST_FULL;
                    else if (p < 1 || p > shadow_count + 1) st = ST_BADPOS;
                    else open_slot(p - 1, val);
                end
                OP_DEL_FRONT: begin
                    if (empty) st = ST_EMPTY;
                    else close_slot(0);
                end
                OP_DEL_BACK: begin
                    if (empty) st = ST_EMPTY;
                    else shadow_count--;
                end
                OP_DEL_POS: begin
                    if (empty) st = ST_EMPTY;
                    else if (p < 1 || p > shadow_count) st = ST_BADPOS;
                    else close_slot(p - 1);
                end
                OP_READOUT: begin
                    if (empty) begin
                        push_word(ST_OK, '0, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < shadow_count; i++)
                            push_word(ST_OK, shadow_list[i], 1'b1,
                                      (i == shadow_count - 1));
                    end
                    return;
                end
                default: st = ST_BADPOS;
            endcase
            push_word(st, '0, 1'b0, 1'b1);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic signed [ELEM_W-1:0] el,
                                   logic ev, logic [CNT_OUT_W-1:0] cnt, logic lst);
            t_list_word w;
            if (expected_words.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word: st=%0d el=%0d ev=%0b cnt=%0d last=%0b",
                             st, el, ev, cnt, lst);
                mismatches++;
                return;
            end
            w = expected_words.pop_front();
            if (st !== w.status || el !== w.element || ev !== w.element_valid ||
                cnt !== w.count_after || lst !== w.last) begin
                if (mismatches < 10)
                    $display("mismatch at %0t: exp st=%0d el=%0d ev=%0b cnt=%0d last=%0b, %s",
                             $realtime, w.status, w.element, w.element_valid,
                             w.count_after, w.last,
                             $sformatf("got st=%0d el=%0d ev=%0b cnt=%0d last=%0b",
                                       st, el, ev, cnt, lst));
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    plc_in_if  in_ch ();
    plc_out_if out_ch ();

    positional_list_insert_delete_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    list_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_request = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.status, out_ch.element, out_ch.element_valid,
                                out_ch.count_after, out_ch.last);
            if (in_ch.valid && in_ch.ready)
                sb.log_request(in_ch.operation, in_ch.position, in_ch.value);
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // one word into the block; called and returns at a falling edge
    task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [ELEM_W-1:0] val);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.position  <= pos;
        in_ch.value     <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Random traffic drifting between filling and draining the list, so that
    // full and empty are both reached often; positions mostly in range.
    task automatic send_random(int n);
        bit               filling;
        int               r;
        int               cnt;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        filling = 1'b1;
        for (int k = 0; k < n; k++) begin
            cnt = sb.stored();
            if (cnt >= CAPACITY) filling = 1'b0;
            if (cnt == 0) filling = 1'b1;
            r = $urandom_range(99);
            if (r < 5)       op = OP_READOUT;
            else if (r < 8)  op = OP_RESERVED;
            else if ((r < 75) == filling)
                op = OP_W'(OP_INS_FRONT + $urandom_range(2));
            else
                op = OP_W'(OP_DEL_FRONT + $urandom_range(2));
            if ($urandom_range(99) < 25)
                pos = POS_W'($urandom_range(63));
            else if (op == OP_INS_POS || cnt == 0)
                pos = POS_W'($urandom_range(cnt + 1, 1));
            else
                pos = POS_W'($urandom_range(cnt, 1));
            send_word(op, pos, pick_value());
        end
    endtask

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_INS_FRONT;
        in_ch.position  = '0;
        in_ch.value     = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty-list cases: empty check wins over the position check
        send_word(OP_READOUT,   6'd0,  32'sd0);
        send_word(OP_DEL_FRONT, 6'd0,  32'sd0);
        send_word(OP_DEL_BACK,  6'd0,  32'sd0);
        send_word(OP_DEL_POS,   6'd0,  32'sd0);
        send_word(OP_DEL_POS,   6'd63, 32'sd0);
        send_word(OP_INS_POS,   6'd0,  32'sd1);
        send_word(OP_INS_POS,   6'd2,  32'sd1);
        // build a short list from the value extremes
        send_word(OP_INS_POS,   6'd1,  32'sd5);
        send_word(OP_INS_FRONT, 6'd0,  32'sh8000_0000);
        send_word(OP_INS_BACK,  6'd0,  32'sh7fff_ffff);
        send_word(OP_INS_POS,   6'd4,  -32'sd1);
        send_word(OP_INS_POS,   6'd2,  32'sd0);
        send_word(OP_INS_POS,   6'd63, 32'sd7);
        send_word(OP_RESERVED,  6'd1,  32'sd9);
        send_word(OP_DEL_POS,   6'd0,  32'sd0);
        send_word(OP_DEL_POS,   6'd6,  32'sd0);
        send_word(OP_READOUT,   6'd0,  32'sd0);
        // take it apart again
        send_word(OP_DEL_POS,   6'd5,  32'sd0);
        send_word(OP_DEL_POS,   6'd2,  32'sd0);
        send_word(OP_DEL_FRONT, 6'd0,  32'sd0);
        send_word(OP_DEL_BACK,  6'd0,  32'sd0);
        send_word(OP_READOUT,   6'd0,  32'sd0);
        send_word(OP_DEL_POS,   6'd1,  32'sd0);
        send_word(OP_READOUT,   6'd0,  32'sd0);

        send_random(100);
        tx_idle_pct = 73;
        send_random(100);
        tx_idle_pct  = 0;
        rx_stall_pct = 73;
        send_random(100);
        tx_idle_pct  = 12;
        rx_stall_pct = 12;
        send_random(100);
        // output held off while input keeps coming: the block must back up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        send_random(80);
        in_ch.valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[positional_list_insert_delete_core.f]
sv/plc_pkg.sv
sv/plc_if.sv
sv/plc_cell.sv
sv/positional_list_insert_delete_core.sv
test/tb.sv
